// ----- hdl/shortest_common_supersequence_unit_assert.svh -----
// assertion helpers shared by the rtl files
`ifndef SHORTEST_COMMON_SUPERSEQUENCE_UNIT_ASSERT_SVH
`define SHORTEST_COMMON_SUPERSEQUENCE_UNIT_ASSERT_SVH

// condition must hold in the same cycle
`define SCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the next cycle
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/scs_pkg.sv -----
package scs_pkg;

   localparam int SYM_W       = 8;
   localparam int KIND_W      = 2;
   localparam int SRC_W       = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // request kinds as they arrive on the port
   localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD_FIRST,
      OP_LOAD_SECOND,
      OP_RUN
   } op_type;

   typedef enum logic [SRC_W-1:0] {
      SRC_COMMON = 2'd0,
      SRC_FIRST  = 2'd1,
      SRC_SECOND = 2'd2
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_TRACE_RD,
      ST_TRACE_EMIT,
      ST_EMPTY
   } engine_state_type;

   typedef struct packed {
      op_type           op;
      logic [SYM_W-1:0] symbol;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ----- hdl/scs_ifc.sv -----
interface scs_req_if import scs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SYM_W-1:0]  symbol;

   modport source (output valid, output kind, output symbol, input ready);
   modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface scs_rsp_if import scs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] out_symbol;
   logic [SRC_W-1:0] out_source;
   logic             is_empty;
   logic             overflow;
   logic             last;

   modport source (output valid, output out_symbol, output out_source, output is_empty,
                   output overflow, output last, input ready);
   modport sink   (input valid, input out_symbol, input out_source, input is_empty,
                   input overflow, input last, output ready);
endinterface

// ----- hdl/scs_front.sv -----
`include "shortest_common_supersequence_unit_assert.svh"

module scs_front import scs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req,
   input  logic      pop,
   output head_type  head
);

   cmd_type                q_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   keep;
   logic                   push;
   op_type                 op;

   // decode kind, unused code is swallowed
   always_comb begin
      keep = 1'b1;
      op   = OP_RUN;
      case (req.kind)
         KIND_FIRST:  op = OP_LOAD_FIRST;
         KIND_SECOND: op = OP_LOAD_SECOND;
         KIND_RUN:    op = OP_RUN;
         default:     keep = 1'b0;
      endcase
   end

   assign req.ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready && keep;

   always_comb begin
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op, symbol: req.symbol};
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   `SCS_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH)), "queue count above depth")
   `SCS_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, (count_ff != '0), "pop from empty queue")

endmodule

// ----- hdl/scs_engine.sv -----
`include "shortest_common_supersequence_unit_assert.svh"

module scs_engine import scs_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  head_type  head,
   output logic      pop,
   scs_rsp_if.source rsp
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIM    = MAX_LEN + 1;
   localparam int CELLS  = DIM * DIM;
   localparam int ADDR_W = $clog2(CELLS);

   engine_state_type state_ff, state_in;

   logic [LEN_W-1:0] len1_ff, len1_in;
   logic [LEN_W-1:0] len2_ff, len2_in;
   logic             dropped_ff, dropped_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] j_ff, j_in;
   logic [LEN_W-1:0] right_ff, right_in;
   logic [LEN_W-1:0] diag_ff, diag_in;

   logic [SYM_W-1:0] first_ram  [0:MAX_LEN-1];
   logic [SYM_W-1:0] second_ram [0:MAX_LEN-1];
   logic [LEN_W-1:0] lcs_ram    [0:CELLS-1];

   logic [SYM_W-1:0] str_a_ff, str_b_ff;
   logic [LEN_W-1:0] rd_a_ff, rd_b_ff;

   logic              wr_first, wr_second;
   logic              tbl_we;
   logic [ADDR_W-1:0] tbl_waddr, tbl_raddr_a, tbl_raddr_b;
   logic [LEN_W-1:0]  tbl_wdata;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   src_type          rsp_src_ff, rsp_src_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             slot_free;
   logic             emit;
   logic             emit_last;
   logic             both_open;
   logic             sym_eq;
   logic             at_edge;
   logic [LEN_W-1:0] fill_val;
   logic [LEN_W-1:0] ni, nj;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [LEN_W-1:0] r,
                                                   input logic [LEN_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c));
   endfunction

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign both_open = (i_ff < len1_ff) && (j_ff < len2_ff);
   assign sym_eq    = (str_a_ff == str_b_ff);
   assign at_edge   = (i_ff == len1_ff) || (j_ff == len2_ff);

   always_comb begin
      if (at_edge) begin
         fill_val = '0;
      end else if (sym_eq) begin
         fill_val = diag_ff + LEN_W'(1);
      end else begin
         fill_val = (rd_a_ff > right_ff) ? rd_a_ff : right_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.cmd.op == OP_RUN) begin
               state_in = (len1_ff == '0 && len2_ff == '0) ? ST_EMPTY : ST_FILL_RD;
            end
         end
         ST_FILL_RD: state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            state_in = (i_ff == '0 && j_ff == '0) ? ST_TRACE_RD : ST_FILL_RD;
         end
         ST_TRACE_RD: state_in = ST_TRACE_EMIT;
         ST_TRACE_EMIT: begin
            if (slot_free) begin
               state_in = emit_last ? ST_IDLE : ST_TRACE_RD;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      pop          = 1'b0;
      wr_first     = 1'b0;
      wr_second    = 1'b0;
      tbl_we       = 1'b0;
      tbl_waddr    = cell_addr(i_ff, j_ff);
      tbl_wdata    = fill_val;
      tbl_raddr_a  = '0;
      tbl_raddr_b  = '0;
      len1_in      = len1_ff;
      len2_in      = len2_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      right_in     = right_ff;
      diag_in      = diag_ff;
      emit         = 1'b0;
      emit_last    = 1'b0;
      ni           = i_ff;
      nj           = j_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.cmd.op)
                  OP_LOAD_FIRST: begin
                     if (len1_ff < LEN_W'(MAX_LEN)) begin
                        wr_first = 1'b1;
                        len1_in  = len1_ff + LEN_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_LOAD_SECOND: begin
                     if (len2_ff < LEN_W'(MAX_LEN)) begin
                        wr_second = 1'b1;
                        len2_in   = len2_ff + LEN_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     i_in = len1_ff;
                     j_in = len2_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL_RD: begin
            if (i_ff < len1_ff) begin
               tbl_raddr_a = cell_addr(i_ff + LEN_W'(1), j_ff);
            end
         end
         ST_FILL_WR: begin
            tbl_we   = 1'b1;
            right_in = fill_val;
            diag_in  = (j_ff == len2_ff) ? '0 : rd_a_ff;
            if (j_ff == '0) begin
               if (i_ff != '0) begin
                  i_in = i_ff - LEN_W'(1);
                  j_in = len2_ff;
               end
            end else begin
               j_in = j_ff - LEN_W'(1);
            end
         end
         ST_TRACE_RD: begin
            if (both_open) begin
               tbl_raddr_a = cell_addr(i_ff + LEN_W'(1), j_ff);
               tbl_raddr_b = cell_addr(i_ff, j_ff + LEN_W'(1));
            end
         end
         ST_TRACE_EMIT: begin
            if (both_open) begin
               // keep both read ports on the same cells while the beat waits
               tbl_raddr_a = cell_addr(i_ff + LEN_W'(1), j_ff);
               tbl_raddr_b = cell_addr(i_ff, j_ff + LEN_W'(1));
               if (sym_eq) begin
                  rsp_sym_in = str_a_ff;
                  rsp_src_in = SRC_COMMON;
                  ni         = i_ff + LEN_W'(1);
                  nj         = j_ff + LEN_W'(1);
               end else if (rd_a_ff < rd_b_ff) begin
                  rsp_sym_in = str_b_ff;
                  rsp_src_in = SRC_SECOND;
                  nj         = j_ff + LEN_W'(1);
               end else begin
                  rsp_sym_in = str_a_ff;
                  rsp_src_in = SRC_FIRST;
                  ni         = i_ff + LEN_W'(1);
               end
            end else if (i_ff < len1_ff) begin
               rsp_sym_in = str_a_ff;
               rsp_src_in = SRC_FIRST;
               ni         = i_ff + LEN_W'(1);
            end else begin
               rsp_sym_in = str_b_ff;
               rsp_src_in = SRC_SECOND;
               nj         = j_ff + LEN_W'(1);
            end
            emit_last    = (ni == len1_ff) && (nj == len2_ff);
            rsp_empty_in = 1'b0;
            rsp_ovf_in   = dropped_ff;
            rsp_last_in  = emit_last;
            if (slot_free) begin
               emit = 1'b1;
               i_in = ni;
               j_in = nj;
            end
         end
         ST_EMPTY: begin
            emit_last    = 1'b1;
            rsp_sym_in   = '0;
            rsp_src_in   = SRC_COMMON;
            rsp_empty_in = 1'b1;
            rsp_ovf_in   = dropped_ff;
            rsp_last_in  = 1'b1;
            emit         = slot_free;
         end
         default: ;
      endcase

      // a finished run forgets both strings
      if (emit && emit_last) begin
         len1_in    = '0;
         len2_in    = '0;
         dropped_in = 1'b0;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len1_ff      <= '0;
         len2_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len1_ff      <= len1_in;
         len2_ff      <= len2_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      right_ff <= right_in;
      diag_ff  <= diag_in;
      if (emit) begin
         rsp_sym_ff   <= rsp_sym_in;
         rsp_src_ff   <= rsp_src_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_ovf_ff   <= rsp_ovf_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // string stores
   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_ram[len1_ff[IDX_W-1:0]] <= head.cmd.symbol;
      end
      if (wr_second) begin
         second_ram[len2_ff[IDX_W-1:0]] <= head.cmd.symbol;
      end
      str_a_ff <= first_ram[i_ff[IDX_W-1:0]];
      str_b_ff <= second_ram[j_ff[IDX_W-1:0]];
   end

   // lcs table, one write and two reads
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         lcs_ram[tbl_waddr] <= tbl_wdata;
      end
      rd_a_ff <= lcs_ram[tbl_raddr_a];
      rd_b_ff <= lcs_ram[tbl_raddr_b];
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_symbol = rsp_sym_ff;
   assign rsp.out_source = rsp_src_ff;
   assign rsp.is_empty   = rsp_empty_ff;
   assign rsp.overflow   = rsp_ovf_ff;
   assign rsp.last       = rsp_last_ff;

   `SCS_ASSERT_SAME(a_pos_bound, clock, reset, (state_ff != ST_IDLE && state_ff != ST_EMPTY), (i_ff <= len1_ff && j_ff <= len2_ff), "table position beyond string length")
   `SCS_ASSERT_NEXT(a_run_clears, clock, reset, (emit && emit_last), (len1_ff == '0 && len2_ff == '0 && !dropped_ff && state_ff == ST_IDLE), "run end did not clear strings")

endmodule

// ----- hdl/shortest_common_supersequence_unit.sv -----
// channel   | role   | beat contents
// ----------+--------+-------------------------------------------------
// req_chan  | sink   | kind, symbol (append to a string or start a run)
// rsp_chan  | source | out_symbol, out_source, is_empty, overflow, last
//
// a load is taken in the idle state; a run fills the table with a read and
// a write state per cell, then emits each symbol with a read and an emit
// state, paced by the single lcs table memory with its registered read
// ports; two empty strings give their single beat from an empty state
// the front accepts one beat a cycle while its two-entry queue has room
// reset is synchronous and active high; strings and table need no clearing
// a stalled result holds the back end, the front keeps queuing until full

module shortest_common_supersequence_unit import scs_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req_chan,
   scs_rsp_if.source rsp_chan
);

   // queue head from the front, pop from the back
   head_type head;
   logic     pop;

   // front: accept beats, decode kind, buffer commands in order
   scs_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   // back: string stores, table fill, trace and output register
   scs_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ----- bench/scs_checker.sv -----
module scs_checker import scs_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic clock,
   input  logic reset,
   scs_req_if   req_mon,
   scs_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      src_type          src;
      logic             empty;
      logic             ovf;
      logic             last;
   } scs_result_type;

   logic [SYM_W-1:0] first_syms  [MAX_LEN];
   logic [SYM_W-1:0] second_syms [MAX_LEN];
   int               first_len;
   int               second_len;
   logic             dropped;
   int               errors;
   scs_result_type   supersequence_due [$];

   initial begin
      first_len     = 0;
      second_len    = 0;
      dropped       = 1'b0;
      errors        = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic void queue_beat(logic [SYM_W-1:0] sym, src_type src, logic empty);
      scs_result_type beat;
      beat.sym   = sym;
      beat.src   = src;
      beat.empty = empty;
      beat.ovf   = dropped;
      beat.last  = 1'b0;
      supersequence_due.push_back(beat);
   endfunction

   // suffix lcs table, then trace from the front of both strings
   task automatic predict_supersequence();
      int             lcs_len [MAX_LEN+1][MAX_LEN+1];
      int             i;
      int             j;
      scs_result_type tail;
      if (first_len == 0 && second_len == 0) begin
         queue_beat('0, SRC_COMMON, 1'b1);
      end else begin
         for (i = first_len; i >= 0; i--) begin
            for (j = second_len; j >= 0; j--) begin
               if (i == first_len || j == second_len) begin
                  lcs_len[i][j] = 0;
               end else if (first_syms[i] == second_syms[j]) begin
                  lcs_len[i][j] = 1 + lcs_len[i+1][j+1];
               end else begin
                  lcs_len[i][j] = (lcs_len[i+1][j] > lcs_len[i][j+1]) ?
                                  lcs_len[i+1][j] : lcs_len[i][j+1];
               end
            end
         end
         i = 0;
         j = 0;
         while (i < first_len && j < second_len) begin
            if (first_syms[i] == second_syms[j]) begin
               queue_beat(first_syms[i], SRC_COMMON, 1'b0);
               i++;
               j++;
            end else if (lcs_len[i+1][j] < lcs_len[i][j+1]) begin
               queue_beat(second_syms[j], SRC_SECOND, 1'b0);
               j++;
            end else begin
               queue_beat(first_syms[i], SRC_FIRST, 1'b0);
               i++;
            end
         end
         for (; i < first_len; i++) queue_beat(first_syms[i], SRC_FIRST, 1'b0);
         for (; j < second_len; j++) queue_beat(second_syms[j], SRC_SECOND, 1'b0);
      end
      tail      = supersequence_due.pop_back();
      tail.last = 1'b1;
      supersequence_due.push_back(tail);
      first_len  = 0;
      second_len = 0;
      dropped    = 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      scs_result_type want;
      if (reset) begin
         first_len  = 0;
         second_len = 0;
         dropped    = 1'b0;
         supersequence_due.delete();
      end else begin
         // results first: a run never answers on the edge that takes it
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (supersequence_due.size() == 0) begin
               $error("unexpected result beat: out_symbol %0h source %0d",
                      rsp_mon.out_symbol, rsp_mon.out_source);
               errors++;
            end else begin
               want = supersequence_due.pop_front();
               if (rsp_mon.out_symbol !== want.sym) begin
                  $error("out_symbol: expected %0h, got %0h", want.sym, rsp_mon.out_symbol);
                  errors++;
               end
               if (rsp_mon.out_source !== want.src) begin
                  $error("source: expected %0d, got %0d", want.src, rsp_mon.out_source);
                  errors++;
               end
               if (rsp_mon.is_empty !== want.empty) begin
                  $error("is_empty: expected %0b, got %0b", want.empty, rsp_mon.is_empty);
                  errors++;
               end
               if (rsp_mon.overflow !== want.ovf) begin
                  $error("overflow: expected %0b, got %0b", want.ovf, rsp_mon.overflow);
                  errors++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_mon.last);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.kind)
               KIND_FIRST: begin
                  if (first_len < MAX_LEN) begin
                     first_syms[first_len] = req_mon.symbol;
                     first_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               KIND_SECOND: begin
                  if (second_len < MAX_LEN) begin
                     second_syms[second_len] = req_mon.symbol;
                     second_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               KIND_RUN: begin
                  predict_supersequence();
               end
               default: begin
               end
            endcase
         end
      end
      fail_count    <= errors;
      pending_count <= supersequence_due.size();
   end

endmodule

// ----- bench/tb_top.sv -----
module tb_top import scs_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                MAX_LEN     = 32;
   // the one kind code the block has no use for
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int pending_count;

   // idling knobs, set per phase by the stimulus
   int idle_pct  = 0;
   int stall_pct = 0;
   // receiver hold-off length, counted down by the receiver process
   int long_hold_cycles = 0;
   // beats sent, kind 3 noise excluded
   int items_sent = 0;

   scs_req_if req_chan ();
   scs_rsp_if rsp_chan ();

   shortest_common_supersequence_unit #(
      .MAX_LEN (MAX_LEN)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   scs_checker #(
      .MAX_LEN (MAX_LEN)
   ) chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // result side: ready changes on the falling edge only
   initial begin : receiver
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            long_hold_cycles--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one beat and wait for it to be taken; returns on a falling edge
   // with valid still high, so a back-to-back beat never drops it
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         // mostly short gaps, now and then a long one
         if ($urandom_range(9) == 0) repeat ($urandom_range(6, 40)) @(negedge clock);
         else repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.kind   <= kind;
      req_chan.symbol <= sym;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] base, bit narrow);
      // a narrow alphabet makes matches and ties common
      if (narrow) return base + SYM_W'($urandom_range(0, 2));
      return SYM_W'($urandom_range(0, 255));
   endfunction

   // two strings with interleaved loads and some unused-kind noise, then a run
   task automatic send_sequence(input int n1, input int n2);
      int               a;
      int               b;
      logic [SYM_W-1:0] base;
      bit               narrow;
      base   = SYM_W'($urandom_range(0, 255));
      narrow = ($urandom_range(99) < 70);
      a      = 0;
      b      = 0;
      while (a < n1 || b < n2) begin
         if ($urandom_range(99) < 8) send_beat(KIND_UNUSED, SYM_W'($urandom_range(0, 255)));
         if (b == n2 || (a < n1 && $urandom_range(1) == 1)) begin
            send_beat(KIND_FIRST, pick_symbol(base, narrow));
            a++;
         end else begin
            send_beat(KIND_SECOND, pick_symbol(base, narrow));
            b++;
         end
      end
      send_beat(KIND_RUN, SYM_W'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int phase;
      int phase_start;
      req_chan.valid  = 1'b0;
      req_chan.kind   = KIND_FIRST;
      req_chan.symbol = '0;

      // held in reset, released on a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // both strings empty
      send_beat(KIND_RUN, 8'h00);
      // only the first string, then only the second
      send_beat(KIND_FIRST, 8'hFF);
      send_beat(KIND_RUN, 8'hFF);
      send_beat(KIND_SECOND, 8'h00);
      send_beat(KIND_RUN, 8'h00);
      // crossed extremes give a mismatch tie that picks the first string; unused kind in between
      send_beat(KIND_FIRST, 8'h00);
      send_beat(KIND_UNUSED, 8'hA5);
      send_beat(KIND_FIRST, 8'hFF);
      send_beat(KIND_SECOND, 8'hFF);
      send_beat(KIND_SECOND, 8'h00);
      send_beat(KIND_RUN, 8'h5A);
      // shared symbols inside longer strings
      send_beat(KIND_FIRST, 8'h55);
      send_beat(KIND_FIRST, 8'hAA);
      send_beat(KIND_SECOND, 8'hAA);
      send_beat(KIND_SECOND, 8'h55);
      send_beat(KIND_SECOND, 8'hAA);
      send_beat(KIND_RUN, 8'h00);
      // identical strings
      send_beat(KIND_FIRST, 8'h3C);
      send_beat(KIND_SECOND, 8'h3C);
      send_beat(KIND_RUN, 8'h3C);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 57; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         phase_start = items_sent;
         if (phase == 0) begin
            // long receiver hold-off while runs keep coming: the queue fills
            // and the input has to stall
            @(posedge clock);
            long_hold_cycles = 300;
            @(negedge clock);
            send_beat(KIND_FIRST, 8'h11);
            send_beat(KIND_RUN, 8'h00);
            send_beat(KIND_RUN, 8'h00);
            send_beat(KIND_SECOND, 8'h22);
            send_beat(KIND_RUN, 8'h00);
            send_beat(KIND_RUN, 8'h00);
            send_beat(KIND_RUN, 8'h00);
         end
         // full strings: symbols past capacity get dropped and flagged
         if (phase == 1) send_sequence(MAX_LEN + 2, $urandom_range(0, 3));
         if (phase == 3) send_sequence($urandom_range(0, 3), MAX_LEN + 1);
         while (items_sent - phase_start < 20)
            send_sequence($urandom_range(0, 6), $urandom_range(0, 6));
      end

      req_chan.valid <= 1'b0;
      idle_pct        = 0;
      while (pending_count != 0) @(posedge clock);
      // room for any stray result after the last expected one
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #4ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/scs_pkg.sv
hdl/scs_ifc.sv
hdl/scs_front.sv
hdl/scs_engine.sv
hdl/shortest_common_supersequence_unit.sv
bench/scs_checker.sv
bench/tb_top.sv
